// ===== hdl/ordq_pkg.sv =====
// ----------------------------------------------------------------------------
// ordq_pkg
// Shared sizes, codes and the controller/datapath interface structs for the
// output-restricted deque.
// ----------------------------------------------------------------------------
package ordq_pkg;

   localparam int DEPTH      = 128;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int VALUE_W    = 32;
   localparam int POS_W      = 7;

   typedef enum logic [1:0] {
      CMD_INS_FRONT = 2'd0,
      CMD_INS_REAR  = 2'd1,
      CMD_REMOVE    = 2'd2,
      CMD_SEARCH    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_OVERFLOW  = 2'd1,
      STS_UNDERFLOW = 2'd2,
      STS_NOT_FOUND = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // input beat taken this cycle
      logic exec_en;  // work on the latched command, result slot is free
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic done;     // latched command finishes this cycle if exec_en
      logic out_free; // result register can take a new beat
   } dp_status_type;

   // value is sign-extended to the storage width, or cut down to it
   function automatic logic [DATA_WIDTH-1:0] to_data(input logic signed [VALUE_W-1:0] v);
      return DATA_WIDTH'(v);
   endfunction

endpackage

// ===== hdl/output_restricted_deque.sv =====
// ----------------------------------------------------------------------------
// output_restricted_deque
// Flow: a command beat is latched while the head entry is prefetched through
//   the single RAM port; the datapath then writes or reads out through the
//   same port and loads the result register. A new command is taken only
//   after the last one is done; search scans one entry per cycle through the
//   same port while the result register is free.
// Reset: synchronous, active high; indices go to 0 and the deque to empty.
//   The store is not cleared, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module output_restricted_deque import ordq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] command
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] removed_value, [38:32] found_position
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   // Controller sequences one beat at a time; the datapath owns the store
   // and a result register, so a new command is taken while a result waits.
   ctrl_cmd_type       dp_cmd;
   dp_status_type      dp_sts;
   logic [VALUE_W-1:0] removed;
   logic [POS_W-1:0]   position;

   ordq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_sts     (dp_sts),
      .dp_cmd     (dp_cmd)
   );

   ordq_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .dp_cmd       (dp_cmd),
      .dp_sts       (dp_sts),
      .req_command  (req_tuser),
      .req_value    (req_tdata),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_status   (rsp_tuser),
      .rsp_removed  (removed),
      .rsp_position (position)
   );

   // pack result beat, top bit padded to a whole byte
   assign rsp_tdata = {1'b0, position, removed};

endmodule

// ===== hdl/ordq_ram.sv =====
// ----------------------------------------------------------------------------
// ordq_ram
// Single-port RAM, write first in priority, registered read data.
// ----------------------------------------------------------------------------
module ordq_ram #(
   parameter int DATA_W = 32,
   parameter int WORDS  = 128
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic                                       re,
   input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] addr,
   input  logic [DATA_W-1:0]                          wdata,
   output logic [DATA_W-1:0]                          rdata
);

   logic [DATA_W-1:0] mem [WORDS];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/ordq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ordq_ctrl
// Sequencer: takes one command beat, then holds in EXEC until the datapath
// reports the command done with the result register free.
// ----------------------------------------------------------------------------
module ordq_ctrl import ordq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type dp_sts,
   output ctrl_cmd_type  dp_cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      dp_cmd.accept  = req_tvalid && ready_ff;
      dp_cmd.exec_en = (state_ff == ST_EXEC) && dp_sts.out_free;
      state_in       = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (dp_cmd.accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (dp_cmd.exec_en && dp_sts.done) state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_tready = ready_ff;

endmodule

// ===== hdl/ordq_dp.sv =====
// ----------------------------------------------------------------------------
// ordq_dp
// Datapath: head/tail indices, empty flag, store RAM, search pointer and the
// result register.
// ----------------------------------------------------------------------------
module ordq_dp import ordq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        dp_cmd,
   output dp_status_type       dp_sts,
   input  logic [1:0]          req_command,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [1:0]          rsp_status,
   output logic [VALUE_W-1:0]  rsp_removed,
   output logic [POS_W-1:0]    rsp_position
);

   localparam logic [IDX_W-1:0] TOP = IDX_W'(DEPTH - 1);
   localparam logic [IDX_W-1:0] ONE = IDX_W'(1);

   logic [IDX_W-1:0]      head_ff, head_in, tail_ff, tail_in, cmp_ff, cmp_in;
   logic                  empty_ff, empty_in;
   cmd_type               cmd_ff;
   logic [DATA_WIDTH-1:0] key_ff;

   logic                  ram_we, ram_re;
   logic [IDX_W-1:0]      ram_addr;
   logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

   status_type            res_status;
   logic [VALUE_W-1:0]    res_removed;
   logic [POS_W-1:0]      res_pos;
   logic                  done;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [VALUE_W-1:0]    rsp_removed_ff;
   logic [POS_W-1:0]      rsp_pos_ff;

   ordq_ram #(
      .DATA_W (DATA_WIDTH),
      .WORDS  (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      empty_in    = empty_ff;
      cmp_in      = cmp_ff;
      ram_we      = 1'b0;
      ram_re      = dp_cmd.accept;   // head entry prefetched for remove/search
      ram_addr    = head_ff;
      ram_wdata   = '0;
      res_status  = STS_OK;
      res_removed = '0;
      res_pos     = '0;
      done        = 1'b1;

      if (dp_cmd.accept) cmp_in = head_ff;

      if (dp_cmd.exec_en) begin
         unique case (cmd_ff)
            CMD_INS_FRONT, CMD_INS_REAR: begin
               ram_wdata = key_ff;
               if (empty_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b0;
                  ram_we   = 1'b1;
                  ram_addr = '0;
               end else if (cmd_ff == CMD_INS_FRONT) begin
                  if (head_ff == '0) begin
                     res_status = STS_OVERFLOW;
                  end else begin
                     head_in  = head_ff - ONE;
                     ram_we   = 1'b1;
                     ram_addr = head_ff - ONE;
                  end
               end else begin
                  if (tail_ff >= TOP) begin
                     res_status = STS_OVERFLOW;
                  end else begin
                     tail_in  = tail_ff + ONE;
                     ram_we   = 1'b1;
                     ram_addr = tail_ff + ONE;
                  end
               end
            end
            CMD_REMOVE: begin
               if (empty_ff || head_ff > tail_ff) begin
                  res_status  = STS_UNDERFLOW;
                  res_removed = '1;
               end else begin
                  res_removed = VALUE_W'(ram_rdata);
                  ram_we      = 1'b1;
                  ram_addr    = head_ff;
                  if (head_ff == tail_ff) begin
                     head_in  = '0;
                     tail_in  = '0;
                     empty_in = 1'b1;
                  end else begin
                     head_in = head_ff + ONE;
                  end
               end
            end
            CMD_SEARCH: begin
               // ram_rdata holds the entry at cmp_ff
               if (empty_ff) begin
                  res_status = STS_NOT_FOUND;
               end else if (ram_rdata == key_ff) begin
                  res_pos = POS_W'(cmp_ff);
               end else if (cmp_ff == tail_ff) begin
                  res_status = STS_NOT_FOUND;
               end else begin
                  done     = 1'b0;
                  ram_re   = 1'b1;
                  ram_addr = cmp_ff + ONE;
                  cmp_in   = cmp_ff + ONE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
         if (dp_cmd.exec_en && done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_ff <= cmp_in;
      if (dp_cmd.accept) begin
         cmd_ff <= cmd_type'(req_command);
         key_ff <= to_data(req_value);
      end
      if (dp_cmd.exec_en && done) begin
         rsp_status_ff  <= res_status;
         rsp_removed_ff <= res_removed;
         rsp_pos_ff     <= res_pos;
      end
   end

   assign dp_sts.done     = done;
   assign dp_sts.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_removed  = rsp_removed_ff;
   assign rsp_position = rsp_pos_ff;

`ifndef SYNTH
   a_order: assert property (@(posedge clock) disable iff (reset)
      !empty_ff |-> head_ff <= tail_ff)
      else $error("head beyond tail in non-empty deque");

   a_empty_idx: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == '0) && (tail_ff == '0))
      else $error("empty deque with non-zero index");

   a_result: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.exec_en && done |=> rsp_valid_ff)
      else $error("finished command left no result beat");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.exec_en && (cmd_ff == CMD_SEARCH) && !empty_ff |->
         (cmp_ff >= head_ff) && (cmp_ff <= tail_ff))
      else $error("search pointer outside head..tail");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for output_restricted_deque. A predictor of the deque
// works out status, removed word and match position for each command beat the
// block takes; the result channel is checked beat by beat against it. Both
// sides idle at random, and the result side holds off for long stretches so
// the block backs up and stalls its command input.
// ----------------------------------------------------------------------------
module tb;
   import ordq_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int ITEM_COUNT  = 550;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      cmd_type     cmd;
      logic [31:0] value;
   } cmd_beat_type;

   typedef struct {
      status_type       status;
      logic [31:0]      removed;
      logic [POS_W-1:0] position;
   } rsp_expect_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [31:0] value
   logic [1:0]  req_tuser;    // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // [31:0] removed_value, [38:32] found_position
   logic [1:0]  rsp_tuser;    // [1:0] status

   output_restricted_deque dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // commands still to be offered, results still owed by the block
   cmd_beat_type   cmd_backlog[$];
   rsp_expect_type rsp_due_q[$];
   // values inserted lately, so searches can hit
   logic [31:0] recent_vals[$];

   // predicted deque contents
   logic [DATA_WIDTH-1:0] dq_store[DEPTH];
   int                    dq_head  = 0;
   int                    dq_tail  = 0;
   bit                    dq_empty = 1'b1;

   int errors      = 0;
   int cmds_taken  = 0;
   int cycle_count = 0;
   int req_wait    = 0;
   int req_calm    = 0;
   int rsp_wait    = 0;
   int rsp_calm    = 0;
   int hold_left   = 0;
   int next_hold_at = 40;

   // ------------------------------------------------------------------------
   // Predictor: one command in, the one result it must produce out.
   // ------------------------------------------------------------------------
   function automatic rsp_expect_type deque_step(cmd_type cmd, logic [31:0] value);
      rsp_expect_type        r;
      logic [DATA_WIDTH-1:0] word;
      bit                    hit;
      r.status   = STS_OK;
      r.removed  = '0;
      r.position = '0;
      word       = DATA_WIDTH'($signed(value));
      hit        = 1'b0;
      case (cmd)
         CMD_INS_FRONT, CMD_INS_REAR: begin
            if (dq_empty) begin
               // either kind lands at position 0 of an empty deque
               dq_head     = 0;
               dq_tail     = 0;
               dq_store[0] = word;
               dq_empty    = 1'b0;
            end else if (cmd == CMD_INS_FRONT) begin
               if (dq_head == 0) begin
                  r.status = STS_OVERFLOW;
               end else begin
                  dq_head--;
                  dq_store[dq_head] = word;
               end
            end else if (dq_tail >= DEPTH - 1) begin
               r.status = STS_OVERFLOW;
            end else begin
               dq_tail++;
               dq_store[dq_tail] = word;
            end
         end
         CMD_REMOVE: begin
            if (dq_empty || dq_head > dq_tail) begin
               r.status  = STS_UNDERFLOW;
               r.removed = '1;
            end else begin
               r.removed         = 32'(dq_store[dq_head]);
               dq_store[dq_head] = '0;
               if (dq_head == dq_tail) begin
                  dq_head  = 0;
                  dq_tail  = 0;
                  dq_empty = 1'b1;
               end else begin
                  dq_head++;
               end
            end
         end
         default: begin
            // scan front to rear, first match wins
            r.status = STS_NOT_FOUND;
            if (!dq_empty) begin
               for (int i = dq_head; i <= dq_tail && !hit; i++) begin
                  if (dq_store[i] == word) begin
                     hit        = 1'b1;
                     r.status   = STS_OK;
                     r.position = POS_W'(i);
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   // idle cycles ahead of the next beat; now and then a calm run with none
   function automatic int next_pause(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 11) == 0) begin
         calm = $urandom_range(15, 60);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic queue_cmd(cmd_type cmd, logic [31:0] value);
      cmd_beat_type b;
      b.cmd   = cmd;
      b.value = value;
      cmd_backlog.push_back(b);
   endtask

   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(0, 5))
         0:       v = $urandom_range(0, 7);   // small range, so duplicates occur
         1: begin
            case ($urandom_range(0, 3))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7FFF_FFFF;
               2:       v = 32'hFFFF_FFFF;
               default: v = 32'h0;
            endcase
         end
         default: v = $urandom;
      endcase
      recent_vals.push_back(v);
      if (recent_vals.size() > 64)
         void'(recent_vals.pop_front());
      return v;
   endfunction

   function automatic logic [31:0] pick_key();
      if (recent_vals.size() != 0 && $urandom_range(0, 3) != 0)
         return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
      return $urandom;
   endfunction

   // rear burst with the odd search mixed in
   task automatic queue_rear_fill(int n);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 7) == 0)
            queue_cmd(CMD_SEARCH, pick_key());
         queue_cmd(CMD_INS_REAR, pick_value());
      end
   endtask

   // pop k from the front, then push k to k + 3 back there
   task automatic queue_front_refill(int k);
      int extra;
      extra = $urandom_range(0, 3);
      for (int j = 0; j < k; j++)
         queue_cmd(CMD_REMOVE, $urandom);
      for (int j = 0; j < k + extra; j++)
         queue_cmd(CMD_INS_FRONT, pick_value());
      queue_cmd(CMD_SEARCH, pick_key());
   endtask

   // ------------------------------------------------------------------------
   // Clock, reset
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Command driver: offers backlog beats, predicts each one taken.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      cmd_beat_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= CMD_INS_FRONT;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            rsp_due_q.push_back(deque_step(cmd_type'(req_tuser), req_tdata));
            cmds_taken <= cmds_taken + 1;
         end
         if (req_wait > 0) begin
            req_tvalid <= 1'b0;
            req_wait   <= req_wait - 1;
         end else if (cmd_backlog.size() != 0) begin
            nxt = cmd_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= nxt.value;
            req_tuser  <= nxt.cmd;
            req_wait   <= next_pause(req_calm);  // gap after this beat
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor: checks each beat against the oldest prediction. Two
   // long hold-offs back the block up so its command side stalls.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : sink_rsp
      rsp_expect_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_due_q.size() == 0) begin
               $error("result beat with nothing outstanding: tuser %0d tdata %h",
                      rsp_tuser, rsp_tdata);
               errors++;
            end else begin
               want = rsp_due_q.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[31:0] !== want.removed) begin
                  $error("removed_value: expected %h, got %h",
                         want.removed, rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[38:32] !== want.position) begin
                  $error("found_position: expected %0d, got %0d",
                         want.position, rsp_tdata[38:32]);
                  errors++;
               end
            end
            rsp_wait = next_pause(rsp_calm);
         end
         if (hold_left == 0 && cmds_taken >= next_hold_at && next_hold_at < 400) begin
            hold_left    = HOLD_CYCLES;
            next_hold_at = next_hold_at + 260;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence, then wait for the block to drain
   // ------------------------------------------------------------------------
   initial begin
      // directed: empty deque cases, field extremes, both overflows later
      queue_cmd(CMD_SEARCH,    32'h0000_0000);   // search in empty deque
      queue_cmd(CMD_REMOVE,    32'hFFFF_FFFF);   // remove from empty deque
      queue_cmd(CMD_INS_FRONT, 32'h7FFF_FFFF);   // front insert into empty
      queue_cmd(CMD_INS_FRONT, 32'h1234_5678);   // head at 0: overflow
      queue_cmd(CMD_INS_REAR,  32'h8000_0000);
      queue_cmd(CMD_INS_REAR,  32'hFFFF_FFFF);
      queue_cmd(CMD_INS_REAR,  32'h0000_0000);
      queue_cmd(CMD_SEARCH,    32'h8000_0000);
      queue_cmd(CMD_SEARCH,    32'hFFFF_FFFF);
      queue_cmd(CMD_SEARCH,    32'h0000_3039);   // not present
      queue_cmd(CMD_REMOVE,    32'h0000_0000);
      queue_cmd(CMD_INS_FRONT, 32'h5555_AAAA);   // head back to 0
      queue_cmd(CMD_SEARCH,    32'h5555_AAAA);
      queue_cmd(CMD_REMOVE,    32'h0000_0000);
      queue_cmd(CMD_REMOVE,    32'h0000_0000);
      queue_cmd(CMD_REMOVE,    32'h0000_0000);
      queue_cmd(CMD_REMOVE,    32'h0000_0000);   // last entry: deque empties
      queue_cmd(CMD_REMOVE,    32'h0000_0000);   // underflow
      queue_cmd(CMD_INS_REAR,  32'hA5A5_A5A5);   // rear insert into empty
      queue_cmd(CMD_REMOVE,    32'h0000_0000);

      // fill to the top of the array so rear inserts overflow, then refill
      // the front from a full array
      queue_rear_fill(DEPTH + 4);
      queue_front_refill($urandom_range(1, 40));

      while (cmd_backlog.size() < ITEM_COUNT) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: queue_rear_fill($urandom_range(20, 140));
            4, 5: begin
               for (int k = $urandom_range(10, 140); k > 0; k--)
                  queue_cmd($urandom_range(0, 7) == 0 ? CMD_SEARCH : CMD_REMOVE,
                            pick_key());
            end
            6, 7: queue_front_refill($urandom_range(1, 40));
            8: begin
               for (int k = 0; k < 10; k++)
                  queue_cmd(CMD_SEARCH, pick_key());
            end
            default: begin
               // noise: any command, any value
               for (int k = 0; k < 8; k++)
                  queue_cmd(cmd_type'($urandom_range(0, 3)), pick_value());
            end
         endcase
      end
      // last burst may overshoot; keep the run at its nominal length
      while (cmd_backlog.size() > ITEM_COUNT)
         void'(cmd_backlog.pop_back());

      do @(posedge clock); while (reset);
      while (cmd_backlog.size() != 0 || req_tvalid || rsp_due_q.size() != 0)
         @(posedge clock);
      // all owed results are in; let any stray beat show up
      repeat (DEPTH + 20) @(posedge clock);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
